FILE: sv/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg - icon format detector package
// Shared sizes, match constants and the verdict codes of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

  // Largest file length that is still scanned, and the first scanned offset
  localparam int unsigned MAX_FILE_BYTES = 65536;
  localparam int unsigned SCAN_START     = 78;

  // Byte counter must hold MAX_FILE_BYTES + 1 (saturated overflow value)
  localparam int unsigned CNT_W = $clog2(MAX_FILE_BYTES + 2);

  // Window of recent bytes, oldest first
  localparam int unsigned WIN = 12;

  localparam logic [31:0] MAGIC_WORD     = 32'hE310_0001;
  localparam logic [31:0] FORM_TAG       = 32'h464F_524D;
  localparam logic [31:0] ICON_TAG       = 32'h4943_4F4E;
  localparam int unsigned USER_WORD_OFFS = 'h2C;

  localparam logic [7:0] CH_W  = 8'h57;
  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_I  = 8'h49;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_EQ = 8'h3D;

  typedef enum logic [1:0] {
    FMT_UNKNOWN = 2'd0,
    FMT_GLOW    = 2'd1,
    FMT_OS13    = 2'd2,
    FMT_OS3     = 2'd3
  } format_t;

  typedef logic [CNT_W-1:0] cnt_t;

endpackage

`default_nettype wire

FILE: sv/icon_format_detector.sv
// ----------------------------------------------------------------------------
// icon_format_detector - classify an icon file streamed one byte at a time
// Scans the byte stream for the magic word, glow markers and FORM/ICON
// chunks and returns one verdict after the byte flagged as last.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle; a request passes an input register and
// the scan logic, and the verdict for a file is loaded into the output register
// when its last byte leaves the input register. The sliding window compare and
// the state update are combinational between the input register and the state
// and result registers. Input only stalls while a verdict waits in the output
// register and the next file's last byte is already in the input register.
`default_nettype none

module icon_format_detector
  import ifd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] file_byte
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,   // is_last
  // out_tdata: [1:0] format, [2] marker_found, [18:3] marker_offset,
  //            [19] too_long, [23:20] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // scan state
  cnt_t        idx_r, idx_nxt;
  logic [7:0]  win_r [WIN];
  logic [7:0]  win_nxt [WIN];
  logic        magic_ok_r, magic_ok_nxt;
  logic [31:0] user_word_r, user_word_nxt;
  logic [15:0] wim_offs_r, wim_offs_nxt;
  logic        wim_seen_r, wim_seen_nxt;
  logic [15:0] im_offs_r, im_offs_nxt;
  logic        im_seen_r, im_seen_nxt;
  logic [15:0] form_offs_r, form_offs_nxt;
  logic        form_seen_r, form_seen_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  logic [31:0] n32;
  logic        scanning;
  logic        wim_hit, im_hit, form_hit;
  logic [31:0] win_head, win_tail;
  format_t     fmt;
  logic        found, over;
  logic [15:0] offs;

  // a request in the input register moves on unless its verdict would
  // overwrite one still waiting
  assign s1_adv       = s1_valid_r && !(s1_last_r && out_valid_r && !out_tready);
  assign in_tready    = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // window after this byte: w[k] is the byte at offset n - 11 + k
  always_comb begin
    for (int k = 0; k < WIN - 1; k++) begin
      win_nxt[k] = win_r[k+1];
    end
    win_nxt[WIN-1] = s1_byte_r;
  end

  assign n32      = 32'(idx_r);
  assign scanning = (n32 < MAX_FILE_BYTES);
  assign win_head = {win_nxt[0], win_nxt[1], win_nxt[2], win_nxt[3]};
  assign win_tail = {win_nxt[8], win_nxt[9], win_nxt[10], win_nxt[11]};

  assign wim_hit = !wim_seen_r && (n32 >= SCAN_START + 4) &&
                   ((win_nxt[7] == CH_W) || (win_nxt[7] == CH_M)) &&
                   (win_nxt[8] == CH_I) && (win_nxt[9] == CH_M) &&
                   (win_nxt[10] == CH_1) && (win_nxt[11] == CH_EQ);
  assign im_hit  = !im_seen_r && !s1_last_r && (n32 >= SCAN_START + 3) &&
                   (win_nxt[8] == CH_I) && (win_nxt[9] == CH_M) &&
                   (win_nxt[10] == CH_1) && (win_nxt[11] == CH_EQ);
  assign form_hit = !form_seen_r && (n32 >= SCAN_START + 11) &&
                    (win_head == FORM_TAG) && (win_tail == ICON_TAG);

  // state update for one byte
  always_comb begin
    idx_nxt       = idx_r;
    magic_ok_nxt  = magic_ok_r;
    user_word_nxt = user_word_r;
    wim_offs_nxt  = wim_offs_r;
    wim_seen_nxt  = wim_seen_r;
    im_offs_nxt   = im_offs_r;
    im_seen_nxt   = im_seen_r;
    form_offs_nxt = form_offs_r;
    form_seen_nxt = form_seen_r;
    if (!scanning) begin
      idx_nxt = CNT_W'(MAX_FILE_BYTES + 1);
    end else begin
      idx_nxt = idx_r + cnt_t'(1);
      if ((n32 < 4) && (s1_byte_r != MAGIC_WORD[(3 - n32[1:0]) * 8 +: 8])) begin
        magic_ok_nxt = 1'b0;
      end
      if ((n32 >= USER_WORD_OFFS) && (n32 < USER_WORD_OFFS + 4)) begin
        user_word_nxt = {user_word_r[23:0], s1_byte_r};
      end
      if (wim_hit) begin
        wim_seen_nxt = 1'b1;
        wim_offs_nxt = 16'(n32 - 32'd4);
      end
      if (im_hit) begin
        im_seen_nxt = 1'b1;
        im_offs_nxt = 16'(n32 - 32'd3);
      end
      if (form_hit) begin
        form_seen_nxt = 1'b1;
        form_offs_nxt = 16'(n32 - 32'd11);
      end
    end
  end

  // verdict from the updated state, in priority order
  always_comb begin
    fmt   = FMT_UNKNOWN;
    found = 1'b0;
    offs  = 16'd0;
    over  = 1'b0;
    if (32'(idx_nxt) > MAX_FILE_BYTES) begin
      over = 1'b1;
    end else if ((32'(idx_nxt) < SCAN_START) || !magic_ok_nxt) begin
      fmt = FMT_UNKNOWN;
    end else if (wim_seen_nxt) begin
      fmt = FMT_GLOW; found = 1'b1; offs = wim_offs_nxt;
    end else if (im_seen_nxt) begin
      fmt = FMT_GLOW; found = 1'b1; offs = im_offs_nxt;
    end else if (form_seen_nxt) begin
      fmt = FMT_GLOW; found = 1'b1; offs = form_offs_nxt;
    end else if (user_word_nxt == 32'd0) begin
      fmt = FMT_OS13;
    end else if (user_word_nxt == 32'd1) begin
      fmt = FMT_OS3;
    end
  end

  // state registers: cleared after each verdict
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_last_r)) begin
      idx_r       <= '0;
      magic_ok_r  <= 1'b1;
      user_word_r <= '0;
      wim_offs_r  <= '0;
      wim_seen_r  <= 1'b0;
      im_offs_r   <= '0;
      im_seen_r   <= 1'b0;
      form_offs_r <= '0;
      form_seen_r <= 1'b0;
      for (int k = 0; k < WIN; k++) begin
        win_r[k] <= '0;
      end
    end else if (s1_adv) begin
      idx_r       <= idx_nxt;
      magic_ok_r  <= magic_ok_nxt;
      user_word_r <= user_word_nxt;
      wim_offs_r  <= wim_offs_nxt;
      wim_seen_r  <= wim_seen_nxt;
      im_offs_r   <= im_offs_nxt;
      im_seen_r   <= im_seen_nxt;
      form_offs_r <= form_offs_nxt;
      form_seen_r <= form_seen_nxt;
      if (scanning) begin
        for (int k = 0; k < WIN; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, over, offs, found, fmt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/ifd_checker.sv
// ----------------------------------------------------------------------------
// ifd_checker - port-level checks for the icon format detector
// Watches the result channel for stable stalls and consistent verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_checker
  import ifd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // no verdict straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("verdict after reset");

  // an overlong file reports nothing else
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |->
      (out_tdata[1:0] == FMT_UNKNOWN) && !out_tdata[2] && (out_tdata[18:3] == 16'd0))
    else $error("too_long verdict carries other fields");

  // a marker is reported exactly for glow icons
  a_marker_glow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2] == (out_tdata[1:0] == FMT_GLOW)))
    else $error("marker flag and glow format disagree");

  // without a marker the offset and the padding read zero
  a_no_marker_offs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> (out_tdata[18:3] == 16'd0) &&
      (out_tdata[23:20] == 4'd0))
    else $error("offset or padding set without marker");

endmodule

bind icon_format_detector ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
